FILE: sv/csws_pkg.sv
// shared types and constants for the chunked sliding window sum
`default_nettype none
package csws_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CHUNK_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int LEN_W    = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = 8'd16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [CHUNK_W-1:0]  chunk_t;
    typedef logic signed [TOTAL_W-1:0]  total_t;
    typedef logic [LEN_W-1:0]           len_t;

    typedef struct packed {
        total_t window_sum;
        logic   chunk_pushed;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/csws_ring_mem.sv
// chunk ring memory with registered read and write-to-read forwarding
`default_nettype none
module csws_ring_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire csws_pkg::chunk_t  wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output csws_pkg::chunk_t       rd_data
);

    csws_pkg::chunk_t mem [DEPTH];
    csws_pkg::chunk_t q_reg;
    csws_pkg::chunk_t fwd_data_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg        <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule
`default_nettype wire

FILE: sv/csws_skid.sv
// output register with skid stage for the result beats
`default_nettype none
module csws_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire csws_pkg::result_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csws_pkg::result_t       out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    csws_pkg::result_t out_data_reg;
    csws_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                out_data_reg <= in_data;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/chunked_sliding_window_sum.sv
// top level of the chunked sliding window sum
//
// input beats on s_axis carry one signed 24-bit sample in tdata. each beat
// adds the sample to the running chunk sum and to the window total. after
// chunk_length samples the chunk sum goes into a ring memory of RING_DEPTH
// entries; when the ring fills, the oldest chunk is read back and
// subtracted from the total. every input beat gives exactly one output
// beat on m_axis: the 40-bit window total in tdata and the chunk-complete
// flag in tuser.
// throughput is one beat per cycle unless m_axis stalls; the oldest ring
// entry is prefetched from the registered read port, with forwarding when
// a write hits the entry being read. a stalled receiver holds the output
// register; one more beat goes into a skid stage, then s_axis_tready drops
// until the receiver takes a beat. reset clears the counters, the sums and
// the ring pointers and sets chunk_length to 16; ring contents need no
// clearing. the user must write chunk_length through cfg_wen and cfg_wdata
// only while no beat is in flight; the block does not enforce this.
`default_nettype none
module chunked_sliding_window_sum #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [7:0]  cfg_wdata,      // chunk_length
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // window_sum
    output logic [0:0]       m_axis_tuser    // chunk_pushed
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(RING_DEPTH);

    csws_pkg::len_t    chunk_length_reg;
    csws_pkg::len_t    chunk_count_reg;
    csws_pkg::len_t    chunk_count_next;
    csws_pkg::chunk_t  chunk_sum_reg;
    csws_pkg::chunk_t  chunk_sum_inc;
    csws_pkg::chunk_t  chunk_sum_next;
    csws_pkg::total_t  total_reg;
    csws_pkg::total_t  total_next;
    csws_pkg::total_t  removed;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     fill_reg;
    logic [AW-1:0]     fill_next;
    logic [AW:0]       wr_sum;
    logic [AW-1:0]     wr_addr;
    logic              accept;
    logic              push;
    logic              remove;
    logic              wr_en;
    csws_pkg::sample_t sample;
    csws_pkg::chunk_t  head_val;
    csws_pkg::result_t result;
    csws_pkg::result_t out_result;

    assign sample           = csws_pkg::sample_t'(s_axis_tdata);
    assign accept           = s_axis_tvalid && s_axis_tready;
    assign chunk_count_next = chunk_count_reg + 8'd1;
    assign chunk_sum_inc    = chunk_sum_reg + csws_pkg::chunk_t'(sample);
    assign push             = chunk_count_next >= chunk_length_reg;
    assign remove           = push && (fill_reg == LAST_IDX);
    assign wr_en            = accept && push;

    assign wr_sum  = {1'b0, head_reg} + {1'b0, fill_reg};
    assign wr_addr = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        chunk_sum_next = push ? '0 : chunk_sum_inc;
        if (accept)
        begin
            if (remove)
            begin
                head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            end
            else if (push)
            begin
                fill_next = fill_reg + AW'(1);
            end
        end
    end

    assign removed    = remove ? csws_pkg::total_t'(head_val) : '0;
    assign total_next = total_reg + csws_pkg::total_t'(sample) - removed;

    assign result.window_sum   = total_next;
    assign result.chunk_pushed = push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_length_reg <= csws_pkg::LEN_RESET;
            chunk_count_reg  <= '0;
            chunk_sum_reg    <= '0;
            total_reg        <= '0;
            head_reg         <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                chunk_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                chunk_count_reg <= push ? '0 : chunk_count_next;
                chunk_sum_reg   <= chunk_sum_next;
                total_reg       <= total_next;
            end
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    csws_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (chunk_sum_inc),
        .rd_addr (head_next),
        .rd_data (head_val)
    );

    csws_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = out_result.window_sum;
    assign m_axis_tuser = out_result.chunk_pushed;

    // ring head stays within the last index while the fill count is at LAST_IDX
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != LAST_IDX || !(head_reg > LAST_IDX))
        else $error("ring head out of range");

    // chunk sum restarts after a completed chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && push |=> chunk_sum_reg == '0 && chunk_count_reg == '0)
        else $error("chunk state not cleared after push");

    // ring pointers stay put on an accepted beat that completes no chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !push |=> $stable(head_reg) && $stable(fill_reg))
        else $error("ring pointers moved without a push");

endmodule
`default_nettype wire
